@@ hw/rtl/perceptual_hash_blocklist_match_assert.svh @@
// Assertion macros shared by the blocklist matcher RTL.
`ifndef PERCEPTUAL_HASH_BLOCKLIST_MATCH_ASSERT_SVH
`define PERCEPTUAL_HASH_BLOCKLIST_MATCH_ASSERT_SVH

// Same-cycle implication.
`define PHBM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PHBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/phbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package phbm_pkg;

   localparam int TABLE_DEPTH_DEF = 64;

   localparam int HASH_W   = 64;
   localparam int THR_W    = 9;
   localparam int TIME_W   = 32;
   localparam int DIST_W   = 8;
   localparam int MIDX_W   = 6;
   localparam int MODE_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int NUM_BYTES = (2 * HASH_W) / BYTE_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_QUERY  = 2'd2
   } mode_type;

   // request fields, lowest bit first: row, col, threshold, exempt, time
   typedef struct packed {
      logic [TIME_W-1:0] time_now;
      logic              exempt;
      logic [THR_W-1:0]  threshold;
      logic [HASH_W-1:0] col_dh;
      logic [HASH_W-1:0] row_dh;
   } req_fields_type;

   localparam int REQ_FIELDS_W = $bits(req_fields_type);
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = MODE_W;

   // one table entry as stored in RAM
   typedef struct packed {
      logic [TIME_W-1:0] last_hit;
      logic [THR_W-1:0]  limit;
      logic [HASH_W-1:0] col_dh;
      logic [HASH_W-1:0] row_dh;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // result word, lowest bit first: status, matched, match_index, hash_distance
   typedef struct packed {
      logic [DIST_W-1:0] hash_distance;
      logic [MIDX_W-1:0] match_index;
      logic              matched;
      logic              status;
   } rsp_fields_type;

   localparam int RSP_TDATA_W = $bits(rsp_fields_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK,
      ST_WB_RD,
      ST_WB_WR,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic cnt_clr;
      logic append_wr;
      logic res_clr;
      logic res_full;
      logic walk_start;
      logic walk_issue;
      logic res_hit;
      logic flush;
      logic wb_rd;
      logic wb_wr;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      mode_type req_mode;
      logic     req_exempt;
      logic     cnt_full;
      logic     cnt_zero;
      logic     issue_done;
      logic     s2_hit;
      logic     s2_miss_last;
      logic     out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/phbm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module phbm_ram #(
   parameter int WIDTH = phbm_pkg::ENTRY_W,
   parameter int DEPTH = phbm_pkg::TABLE_DEPTH_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/phbm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "perceptual_hash_blocklist_match_assert.svh"

module phbm_datapath #(
   parameter int TABLE_DEPTH = phbm_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [phbm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic [phbm_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [phbm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  wire phbm_pkg::cmd_type                   cmd,
   output phbm_pkg::sts_type                        sts
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   // captured request
   phbm_pkg::req_fields_type req_ff, req_in;
   phbm_pkg::mode_type       mode_ff, mode_in;

   // table fill and walk pointer
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;

   // RAM port
   logic                         ram_wr_en;
   logic [IDX_W-1:0]             ram_wr_addr;
   phbm_pkg::entry_type          ram_wr_entry;
   logic                         ram_rd_en;
   logic [IDX_W-1:0]             ram_rd_addr;
   logic [phbm_pkg::ENTRY_W-1:0] ram_rd_data;
   phbm_pkg::entry_type          rd_entry;

   // stage 1: RAM read word
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_last_ff, s1_last_in;
   logic [IDX_W-1:0] s1_idx_ff, s1_idx_in;

   // stage 2: per-byte counts
   logic                       s2_valid_ff, s2_valid_in;
   logic                       s2_last_ff, s2_last_in;
   logic [IDX_W-1:0]           s2_idx_ff, s2_idx_in;
   logic [phbm_pkg::THR_W-1:0] s2_limit_ff, s2_limit_in;
   logic [3:0]                 s2_cnt_ff [phbm_pkg::NUM_BYTES];
   logic [3:0]                 s2_cnt_in [phbm_pkg::NUM_BYTES];

   logic [2*phbm_pkg::HASH_W-1:0] diff;
   logic [4:0]                    sum1 [8];
   logic [5:0]                    sum2 [4];
   logic [6:0]                    sum3 [2];
   logic [phbm_pkg::DIST_W-1:0]   ham_dist;
   logic                          hit;

   // result
   logic                        res_status_ff, res_status_in;
   logic                        res_matched_ff, res_matched_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [phbm_pkg::DIST_W-1:0] res_dist_ff, res_dist_in;
   phbm_pkg::rsp_fields_type    res_word;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [phbm_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ---------------- request capture
   always_comb begin
      req_in  = req_ff;
      mode_in = mode_ff;
      if (cmd.capture) begin
         req_in  = phbm_pkg::req_fields_type'(req_tdata[phbm_pkg::REQ_FIELDS_W-1:0]);
         mode_in = phbm_pkg::mode_type'(req_tuser);
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      mode_ff <= mode_in;
   end

   // ---------------- count and pointer
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.append_wr) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      ptr_in = ptr_ff;
      if (cmd.walk_start || cmd.cnt_clr) begin
         ptr_in = '0;
      end else if (cmd.walk_issue) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         ptr_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         ptr_ff <= ptr_in;
      end
   end

   // ---------------- entry RAM
   assign rd_entry = phbm_pkg::entry_type'(ram_rd_data);

   always_comb begin
      ram_wr_en   = cmd.append_wr | cmd.wb_wr;
      ram_wr_addr = cmd.wb_wr ? hit_idx_ff : cnt_ff[IDX_W-1:0];
      if (cmd.wb_wr) begin
         // hit write-back: keep the entry, stamp the time
         ram_wr_entry          = rd_entry;
         ram_wr_entry.last_hit = req_ff.time_now;
      end else begin
         ram_wr_entry.last_hit = req_ff.time_now;
         ram_wr_entry.limit    = req_ff.threshold;
         ram_wr_entry.col_dh   = req_ff.col_dh;
         ram_wr_entry.row_dh   = req_ff.row_dh;
      end
      ram_rd_en   = cmd.walk_issue | cmd.wb_rd;
      ram_rd_addr = cmd.wb_rd ? hit_idx_ff : ptr_ff[IDX_W-1:0];
   end

   phbm_ram #(
      .WIDTH (phbm_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------- compare pipeline
   assign diff = {rd_entry.col_dh ^ req_ff.col_dh, rd_entry.row_dh ^ req_ff.row_dh};

   always_comb begin
      for (int b = 0; b < phbm_pkg::NUM_BYTES; b++) begin
         s2_cnt_in[b] = '0;
         for (int k = 0; k < phbm_pkg::BYTE_W; k++) begin
            s2_cnt_in[b] = s2_cnt_in[b] + 4'(diff[b*phbm_pkg::BYTE_W+k]);
         end
      end
   end

   always_comb begin
      s1_valid_in = cmd.walk_issue & ~cmd.flush;
      s1_last_in  = (ptr_ff + CNT_W'(1)) == cnt_ff;
      s1_idx_in   = ptr_ff[IDX_W-1:0];
      s2_valid_in = s1_valid_ff & ~cmd.flush;
      s2_last_in  = s1_last_ff;
      s2_idx_in   = s1_idx_ff;
      s2_limit_in = rd_entry.limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_last_ff  <= s1_last_in;
      s1_idx_ff   <= s1_idx_in;
      s2_last_ff  <= s2_last_in;
      s2_idx_ff   <= s2_idx_in;
      s2_limit_ff <= s2_limit_in;
      s2_cnt_ff   <= s2_cnt_in;
   end

   // adder tree over byte counts
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         sum1[i] = 5'(s2_cnt_ff[2*i]) + 5'(s2_cnt_ff[2*i+1]);
      end
      for (int i = 0; i < 4; i++) begin
         sum2[i] = 6'(sum1[2*i]) + 6'(sum1[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
         sum3[i] = 7'(sum2[2*i]) + 7'(sum2[2*i+1]);
      end
      ham_dist = phbm_pkg::DIST_W'(sum3[0]) + phbm_pkg::DIST_W'(sum3[1]);
   end

   // negative limit disables the entry
   assign hit = s2_valid_ff && !s2_limit_ff[phbm_pkg::THR_W-1]
             && ({1'b0, ham_dist} <= s2_limit_ff);

   // ---------------- result
   always_comb begin
      res_status_in  = res_status_ff;
      res_matched_in = res_matched_ff;
      hit_idx_in     = hit_idx_ff;
      res_dist_in    = res_dist_ff;
      if (cmd.res_clr) begin
         res_status_in  = 1'b0;
         res_matched_in = 1'b0;
         hit_idx_in     = '0;
         res_dist_in    = '0;
      end
      if (cmd.res_full) begin
         res_status_in = 1'b1;
      end
      if (cmd.res_hit) begin
         res_matched_in = 1'b1;
         hit_idx_in     = s2_idx_ff;
         res_dist_in    = ham_dist;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff  <= res_status_in;
      res_matched_ff <= res_matched_in;
      hit_idx_ff     <= hit_idx_in;
      res_dist_ff    <= res_dist_in;
   end

   always_comb begin
      res_word.status        = res_status_ff;
      res_word.matched       = res_matched_ff;
      res_word.match_index   = phbm_pkg::MIDX_W'(hit_idx_ff);
      res_word.hash_distance = res_dist_ff;
   end

   // ---------------- output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- status
   always_comb begin
      sts.req_mode     = mode_ff;
      sts.req_exempt   = req_ff.exempt;
      sts.cnt_full     = cnt_ff == DEPTH_C;
      sts.cnt_zero     = cnt_ff == '0;
      sts.issue_done   = ptr_ff == cnt_ff;
      sts.s2_hit       = hit;
      sts.s2_miss_last = s2_valid_ff & s2_last_ff & ~hit;
      sts.out_free     = ~rsp_valid_ff | rsp_tready;
   end

   `PHBM_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= DEPTH_C, "fill count past depth")
   `PHBM_ASSERT_IMPL(a_ptr_bound, clock, reset, 1'b1, ptr_ff <= cnt_ff, "walk pointer past fill")
   `PHBM_ASSERT_IMPL(a_s2_in_table, clock, reset, s2_valid_ff, CNT_W'(s2_idx_ff) < cnt_ff, "compare of unfilled entry")

endmodule

`default_nettype wire

@@ hw/rtl/phbm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "perceptual_hash_blocklist_match_assert.svh"

module phbm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire phbm_pkg::sts_type sts,
   output phbm_pkg::cmd_type      cmd
);

   phbm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= phbm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         phbm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = phbm_pkg::ST_DISPATCH;
            end
         end
         phbm_pkg::ST_DISPATCH: begin
            cmd.res_clr = 1'b1;
            state_in    = phbm_pkg::ST_RESP;
            unique case (sts.req_mode)
               phbm_pkg::MODE_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
               end
               phbm_pkg::MODE_APPEND: begin
                  if (sts.cnt_full) begin
                     cmd.res_full = 1'b1;
                  end else begin
                     cmd.append_wr = 1'b1;
                  end
               end
               phbm_pkg::MODE_QUERY: begin
                  if (!sts.req_exempt && !sts.cnt_zero) begin
                     cmd.walk_start = 1'b1;
                     cmd.flush      = 1'b1;
                     state_in       = phbm_pkg::ST_WALK;
                  end
               end
               default: begin
                  // unused mode: empty result
               end
            endcase
         end
         phbm_pkg::ST_WALK: begin
            if (sts.s2_hit) begin
               cmd.res_hit = 1'b1;
               cmd.flush   = 1'b1;
               state_in    = phbm_pkg::ST_WB_RD;
            end else begin
               cmd.walk_issue = ~sts.issue_done;
               if (sts.s2_miss_last) begin
                  state_in = phbm_pkg::ST_RESP;
               end
            end
         end
         phbm_pkg::ST_WB_RD: begin
            cmd.wb_rd = 1'b1;
            state_in  = phbm_pkg::ST_WB_WR;
         end
         phbm_pkg::ST_WB_WR: begin
            cmd.wb_wr = 1'b1;
            state_in  = phbm_pkg::ST_RESP;
         end
         phbm_pkg::ST_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = phbm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = phbm_pkg::ST_IDLE;
         end
      endcase
   end

   `PHBM_ASSERT_IMPL(a_load_when_free, clock, reset, cmd.out_load, sts.out_free, "result overwrites held word")
   `PHBM_ASSERT_IMPL(a_walk_nonempty, clock, reset, state_ff == phbm_pkg::ST_WALK, !sts.cnt_zero, "walk over empty table")
   `PHBM_ASSERT_NEXT(a_capture_dispatch, clock, reset, cmd.capture, state_ff == phbm_pkg::ST_DISPATCH, "accepted word not decoded")

endmodule

`default_nettype wire

@@ hw/rtl/perceptual_hash_blocklist_match.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Ports                              | Word
// ---------+-----+------------------------------------+-------------------------------------
// req      | in  | req_tvalid req_tready req_tdata    | one command: clear, append or query
//          |     | req_tuser                          |
// rsp      | out | rsp_tvalid rsp_tready rsp_tdata    | one result word per request word
//
// Flow: one word in flight; clear, append, exempt and empty-table queries load a result
// straight after decode, a query after walking the filled entries up to the first hit, and a hit
// after its stamp is read back and rewritten; the block returns to idle before taking the next word.
// Reset: control state, fill count, walk pointer and valid bits clear; entries are
// undefined until appended and never read past the fill count (no clearing pass).
// Stalls: the next word is taken while a result is held; the one after waits, req_tready low.

module perceptual_hash_blocklist_match #(
   parameter int TABLE_DEPTH = phbm_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: tdata = row_dh[63:0], col_dh[127:64], threshold[136:128],
   //          exempt[137], time_now[169:138], zero fill [175:170]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [phbm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [phbm_pkg::REQ_TUSER_W-1:0] req_tuser,  // mode[1:0]
   // result: tdata = status[0], matched[1], match_index[7:2], hash_distance[15:8]
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [phbm_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   phbm_pkg::cmd_type cmd;
   phbm_pkg::sts_type sts;

   // sequencer: accept, decode, walk, time stamp write-back, result hand-off
   phbm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: request latch, entry RAM, Hamming pipeline, result and output regs
   phbm_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

// Blocklist matcher bench.
// Commands go in as clear / append / query words; a shadow copy of the hash table
// predicts each result word, and the result stream is checked against it in order.
// Random traffic is built as sessions: clear, grow the table (sometimes to full and
// past it), then mostly queries aimed near stored hashes so that hits land at
// varied indexes and distances.
module tb_top;

   localparam int TABLE_DEPTH   = phbm_pkg::TABLE_DEPTH_DEF;
   localparam int MODE_W        = phbm_pkg::MODE_W;
   localparam int HASH_W        = phbm_pkg::HASH_W;
   localparam int THR_W         = phbm_pkg::THR_W;
   localparam int TIME_W        = phbm_pkg::TIME_W;
   localparam int MIDX_W        = phbm_pkg::MIDX_W;
   localparam int DIST_W        = phbm_pkg::DIST_W;
   localparam int REQ_TDATA_W   = phbm_pkg::REQ_TDATA_W;
   localparam int REQ_FIELDS_W  = phbm_pkg::REQ_FIELDS_W;
   localparam int REQ_TUSER_W   = phbm_pkg::REQ_TUSER_W;
   localparam int RSP_TDATA_W   = phbm_pkg::RSP_TDATA_W;
   localparam int RANDOM_WORDS  = 1130;
   localparam int IDLE_LIMIT    = 4000;   // cycles with no handshake on either side
   localparam int END_DRAIN     = 100;    // > longest query walk plus write-back
   localparam int HOLD_AT_WORD  = 400;    // long output stall starts after this many words
   localparam int HOLD_CYCLES   = 600;

   // code the block ignores; it still answers with an all-zero word
   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

   typedef struct {
      logic [MODE_W-1:0]        mode;
      phbm_pkg::req_fields_type f;
   } cmd_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // stimulus side
   cmd_word_type   pending_cmds[$];
   cmd_word_type   cmd_on_bus;
   int             total_words    = 0;
   int             accepted_words = 0;
   int             send_idle      = 0;
   int             send_calm      = 0;
   int             recv_idle      = 0;
   int             recv_calm      = 0;
   int             hold_left      = 0;
   logic           hold_armed     = 1'b1;
   logic           rsp_hold;
   int             idle_cycles    = 0;
   int             mismatch_count = 0;

   // generation-time view of the table, used to aim queries at stored hashes and to pace session fill
   logic [HASH_W-1:0] shadow_row[$];
   logic [HASH_W-1:0] shadow_col[$];

   // bench copy of the table state
   logic [HASH_W-1:0]       tbl_row[TABLE_DEPTH];
   logic [HASH_W-1:0]       tbl_col[TABLE_DEPTH];
   logic signed [THR_W-1:0] tbl_limit[TABLE_DEPTH];
   logic [TIME_W-1:0]       tbl_last_hit[TABLE_DEPTH];
   int                      tbl_fill = 0;

   phbm_pkg::rsp_fields_type expected_verdicts[$];

   perceptual_hash_blocklist_match i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction: one verdict per accepted command word, in order.
   // ------------------------------------------------------------------
   function automatic void predict_blocklist_result(cmd_word_type cmd);
      phbm_pkg::rsp_fields_type verdict;
      int lim;
      int ham;
      logic found;
      verdict = '0;
      found = 1'b0;
      case (cmd.mode)
         phbm_pkg::MODE_CLEAR: begin
            tbl_fill = 0;   // entries stay, only the fill count drops
         end
         phbm_pkg::MODE_APPEND: begin
            if (tbl_fill >= TABLE_DEPTH) begin
               verdict.status = 1'b1;   // full table: dropped
            end else begin
               tbl_row[tbl_fill]      = cmd.f.row_dh;
               tbl_col[tbl_fill]      = cmd.f.col_dh;
               tbl_limit[tbl_fill]    = $signed(cmd.f.threshold);
               tbl_last_hit[tbl_fill] = cmd.f.time_now;
               tbl_fill++;
            end
         end
         phbm_pkg::MODE_QUERY: begin
            // exempt images never match; otherwise first enabled entry in range wins
            if (!cmd.f.exempt) begin
               for (int i = 0; i < tbl_fill; i++) begin
                  lim = int'(tbl_limit[i]);
                  if (!found && lim >= 0) begin
                     ham = $countones(tbl_row[i] ^ cmd.f.row_dh)
                         + $countones(tbl_col[i] ^ cmd.f.col_dh);
                     if (ham <= lim) begin
                        found                 = 1'b1;
                        tbl_last_hit[i]       = cmd.f.time_now;
                        verdict.matched       = 1'b1;
                        verdict.match_index   = i[MIDX_W-1:0];
                        verdict.hash_distance = ham[DIST_W-1:0];
                     end
                  end
               end
            end
         end
         default: ;   // reserved code: all-zero word
      endcase
      expected_verdicts.insert(expected_verdicts.size(), verdict);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_result(input phbm_pkg::rsp_fields_type got);
      phbm_pkg::rsp_fields_type want;
      if (expected_verdicts.size() == 0) begin
         report_mismatch($sformatf("result word %h with nothing outstanding", got));
         return;
      end
      want = expected_verdicts.pop_front();
      if (got.status != want.status)
         report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.matched != want.matched)
         report_mismatch($sformatf("matched %0d, expected %0d", got.matched, want.matched));
      if (got.match_index != want.match_index)
         report_mismatch($sformatf("match_index %0d, expected %0d",
                                   got.match_index, want.match_index));
      if (got.hash_distance != want.hash_distance)
         report_mismatch($sformatf("hash_distance %0d, expected %0d",
                                   got.hash_distance, want.hash_distance));
   endtask

   // Gap before the next word, drawn at random, with occasional back-to-back stretches.
   function automatic int draw_idle(inout int calm_left);
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------
   task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [HASH_W-1:0] row,
                            input logic [HASH_W-1:0] col, input logic [THR_W-1:0] thr,
                            input logic exempt, input logic [TIME_W-1:0] stamp);
      cmd_word_type cmd;
      cmd.mode         = mode;
      cmd.f.row_dh     = row;
      cmd.f.col_dh     = col;
      cmd.f.threshold  = thr;
      cmd.f.exempt     = exempt;
      cmd.f.time_now   = stamp;
      pending_cmds.insert(pending_cmds.size(), cmd);
      total_words++;
      if (mode == phbm_pkg::MODE_CLEAR) begin
         shadow_row.delete();
         shadow_col.delete();
      end else if (mode == phbm_pkg::MODE_APPEND && shadow_row.size() < TABLE_DEPTH) begin
         shadow_row.insert(shadow_row.size(), row);
         shadow_col.insert(shadow_col.size(), col);
      end
   endtask

   function automatic logic [HASH_W-1:0] rand_hash();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [TIME_W-1:0] rand_stamp();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_append();
      logic [THR_W-1:0] thr;
      case ($urandom_range(0, 9))
         0:       thr = '1;                              // -1, disabled
         1:       thr = THR_W'($urandom_range(256, 511)); // any negative
         2:       thr = THR_W'($urandom_range(129, 255)); // beyond max distance
         3:       thr = THR_W'(128);
         default: thr = THR_W'($urandom_range(0, 40));
      endcase
      queue_cmd(phbm_pkg::MODE_APPEND, rand_hash(), rand_hash(), thr, 1'($urandom),
                rand_stamp());
   endtask

   // Mostly a stored hash with a few bits flipped, so distances sit near thresholds.
   task automatic queue_query();
      logic [HASH_W-1:0] row;
      logic [HASH_W-1:0] col;
      int pick;
      int flips;
      int b;
      row = rand_hash();
      col = rand_hash();
      if (shadow_row.size() != 0 && $urandom_range(0, 9) < 7) begin
         pick  = $urandom_range(0, shadow_row.size() - 1);
         row   = shadow_row[pick];
         col   = shadow_col[pick];
         flips = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 12);
         for (int k = 0; k < flips; k++) begin
            b = $urandom_range(0, 2 * HASH_W - 1);
            if (b < HASH_W) row[b] = ~row[b];
            else            col[b - HASH_W] = ~col[b - HASH_W];
         end
      end
      queue_cmd(phbm_pkg::MODE_QUERY, row, col, THR_W'($urandom),
                ($urandom_range(0, 9) == 0), rand_stamp());
   endtask

   // ------------------------------------------------------------------
   // Driver: one command word at a time from pending_cmds.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_blocklist_result(cmd_on_bus);
            accepted_words <= accepted_words + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (send_idle != 0) begin
               send_idle--;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               cmd_on_bus = pending_cmds.pop_front();
               req_tuser  <= cmd_on_bus.mode;
               req_tdata  <= {{(REQ_TDATA_W - REQ_FIELDS_W){1'b0}}, cmd_on_bus.f};
               req_tvalid <= 1'b1;
               send_idle  = draw_idle(send_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long output stall: block should back up and drop req_tready.
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && accepted_words >= HOLD_AT_WORD) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   assign rsp_hold = (hold_left != 0);

   // Monitor: check each result word, then idle a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata);
            recv_idle = draw_idle(recv_calm);
         end else if (recv_idle != 0 && !rsp_hold) begin
            recv_idle--;
         end
         rsp_tready <= !rsp_hold && (recv_idle == 0);
      end
   end

   // Watchdog: any handshake resets the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      int random_words;
      int fill_goal;
      int session_len;
      int pick;
      random_words = 0;

      // directed: empty table, extreme hashes/thresholds/stamps, disabled entries,
      // exempt query, max distance hit, reserved code, clear then query
      queue_cmd(phbm_pkg::MODE_QUERY,  '1, '1, '0, 1'b0, 32'h1);
      queue_cmd(phbm_pkg::MODE_APPEND, '0, '0, '0, 1'b0, '0);
      queue_cmd(phbm_pkg::MODE_APPEND, '1, '1, THR_W'(128), 1'b1, '1);
      queue_cmd(phbm_pkg::MODE_APPEND, '0, '0, '1, 1'b0, 32'h1234_5678);
      queue_cmd(phbm_pkg::MODE_APPEND, '0, '0, 9'h100, 1'b0, 32'h8000_0000);
      queue_cmd(phbm_pkg::MODE_APPEND, {32{2'b01}}, {32{2'b10}}, 9'h0FF, 1'b0,
                32'h7FFF_FFFF);
      queue_cmd(phbm_pkg::MODE_QUERY,  '0, '0, '0, 1'b0, 32'hA5A5_A5A5);    // hit entry 0
      queue_cmd(phbm_pkg::MODE_QUERY,  '0, '0, '1, 1'b1, '1);               // exempt
      queue_cmd(phbm_pkg::MODE_QUERY,  64'h1, '0, '0, 1'b0, 32'h5A5A_5A5A); // skips 0, hits 1
      queue_cmd(phbm_pkg::MODE_QUERY,  '1, '1, '0, 1'b0, '1);               // hits 1, dist 0
      queue_cmd(MODE_RESERVED, '1, '1, '1, 1'b1, '1);
      queue_cmd(phbm_pkg::MODE_QUERY,  {32{2'b01}}, {32{2'b10}}, '0, 1'b0,
                32'h3);                                                     // wide threshold
      queue_cmd(phbm_pkg::MODE_CLEAR,  '1, '1, '1, 1'b1, '1);
      queue_cmd(phbm_pkg::MODE_QUERY,  '0, '0, '0, 1'b0, 32'h4);            // nothing after clear
      queue_cmd(phbm_pkg::MODE_APPEND, '0, '0, THR_W'(128), 1'b0, '0);
      queue_cmd(phbm_pkg::MODE_QUERY,  '1, '1, '0, 1'b0, 32'h5);            // dist 128 hit
      queue_cmd(phbm_pkg::MODE_CLEAR,  '0, '0, '0, 1'b0, '0);

      // random sessions; some fill the table and overflow it
      while (random_words < RANDOM_WORDS) begin
         queue_cmd(phbm_pkg::MODE_CLEAR, rand_hash(), rand_hash(), THR_W'($urandom),
                   1'($urandom), rand_stamp());
         random_words++;
         fill_goal   = ($urandom_range(0, 3) == 0) ? TABLE_DEPTH : $urandom_range(1, 24);
         session_len = fill_goal + $urandom_range(30, 80);
         for (int k = 0; k < session_len && random_words < RANDOM_WORDS; k++) begin
            if (shadow_row.size() < fill_goal && $urandom_range(0, 4) != 0) begin
               queue_append();
               random_words++;
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 80) begin
                  queue_query();
                  random_words++;
               end else if (pick < 92) begin
                  queue_append();
                  random_words++;
               end else if (pick < 97) begin
                  queue_cmd(MODE_RESERVED, rand_hash(), rand_hash(), THR_W'($urandom),
                            1'($urandom), rand_stamp());
                  random_words++;
               end else begin
                  queue_cmd(phbm_pkg::MODE_CLEAR, rand_hash(), rand_hash(),
                            THR_W'($urandom), 1'($urandom), rand_stamp());
                  random_words++;
               end
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (!(accepted_words == total_words && expected_verdicts.size() == 0))
         @(negedge clock);
      repeat (END_DRAIN) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/phbm_pkg.sv
hw/rtl/phbm_ram.sv
hw/rtl/phbm_datapath.sv
hw/rtl/phbm_ctrl.sv
hw/rtl/perceptual_hash_blocklist_match.sv
sim/tb_top.sv
